// ===== src/grid_cycle_cover_counter_assert.svh =====
// Assertion macros for the grid cycle cover counter.
`ifndef GRID_CYCLE_COVER_COUNTER_ASSERT_SVH
`define GRID_CYCLE_COVER_COUNTER_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define GCCC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off during reset.
`define GCCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/gccc_pkg.sv =====
// Shared types and constants of the grid cycle cover counter.
`default_nettype none

package gccc_pkg;

	localparam int GRID_WIDTH_W = 4;
	localparam int WAYS_W       = 64;

	typedef enum logic [1:0] {
		PASS_CLEAR,
		PASS_SHIFT,
		PASS_CELL
	} pass_mode_t;

	typedef enum logic [2:0] {
		ST_BOOT,
		ST_BOOT_CLR,
		ST_IDLE,
		ST_CLEAR,
		ST_SHIFT,
		ST_CELL,
		ST_EMIT
	} gccc_state_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic wr_all;
		logic done;
	} eng_ctl_t;

endpackage

`default_nettype wire

// ===== src/gccc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gccc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16384
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== src/gccc_engine.sv =====
// Shared pass engine: sweeps profile pairs, one read and one write per cycle.
`default_nettype none

module gccc_engine #(
	parameter int MAX_WIDTH = 12,
	localparam int AW = MAX_WIDTH + 1,
	localparam int WW = $clog2(MAX_WIDTH + 1),
	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire gccc_pkg::pass_mode_t          mode,
	input  wire logic                          cell_open,
	input  wire logic [CW-1:0]                 col,
	input  wire logic [WW-1:0]                 width,
	output      gccc_pkg::eng_ctl_t            ctl,
	output      logic [AW-1:0]                 rd_addr,
	input  wire logic [gccc_pkg::WAYS_W-1:0]   rd_data,
	output      logic [AW-1:0]                 wr_addr,
	output      logic [gccc_pkg::WAYS_W-1:0]   wr_data
);

	import gccc_pkg::*;

	localparam int NBW = $clog2(AW + 1);

	pass_mode_t        mode_q;
	logic              run_q;
	logic [AW-1:0]     c_q;

	logic              v_s1;
	logic              h_s1;
	logic              last_s1;
	logic [AW-1:0]     k0_s1;
	logic [AW-1:0]     k1_s1;

	logic [WAYS_W-1:0] a_q;
	logic              wf_q;
	logic              ws_q;
	logic              wlast_q;
	logic [AW-1:0]     k0_q;
	logic [AW-1:0]     k1_q;
	logic [WAYS_W-1:0] d0_q;
	logic [WAYS_W-1:0] d1_q;

	logic [NBW-1:0]    nbits;
	logic [AW-1:0]     lim;
	logic              is_last;
	logic              clearing;
	logic              issue;
	logic [AW-1:0]     rz;
	logic [AW-1:0]     left;
	logic [AW-1:0]     up;
	logic [AW-1:0]     lowmask;
	logic [AW-1:0]     k0;
	logic [AW-1:0]     k1;
	logic              comp;
	logic              x;
	logic [WAYS_W-1:0] b;
	logic [WAYS_W-1:0] d0;
	logic [WAYS_W-1:0] d1;

	always_comb begin
		clearing = run_q && (mode_q == PASS_CLEAR);
		issue    = run_q && (mode_q != PASS_CLEAR);
		nbits    = (mode_q == PASS_CLEAR) ? NBW'(AW) : NBW'(width) + NBW'(1);
		lim      = ~({AW{1'b1}} << nbits);
		is_last  = (c_q == lim);

		rz      = {1'b0, c_q[AW-1:1]};
		left    = AW'(1) << col;
		up      = left << 1;
		lowmask = (mode_q == PASS_CELL) ? (up - AW'(1)) : '0;
		k0      = ((rz & ~lowmask) << 1) | (rz & lowmask);
		k1      = (mode_q == PASS_CELL) ? (k0 ^ left ^ up) : (k0 | AW'(1));
		rd_addr = c_q[0] ? k1 : ((mode_q == PASS_SHIFT) ? rz : k0);

		comp = v_s1 && h_s1;
		x    = (k0_s1 & left) != '0;
		b    = rd_data;
		d0   = '0;
		d1   = '0;
		case (mode_q)
			PASS_CELL: begin
				if (cell_open) begin
					d0 = b + (x ? a_q : '0);
					d1 = a_q + (x ? b : '0);
				end else begin
					d0 = x ? '0 : a_q;
				end
			end
			PASS_SHIFT: begin
				d0 = a_q;
			end
			default: begin
				d0 = '0;
			end
		endcase

		ctl.rd_en  = issue;
		ctl.wr_en  = clearing || wf_q || ws_q;
		ctl.wr_all = clearing;
		ctl.done   = (clearing && is_last) || (ws_q && wlast_q);
		if (clearing) begin
			wr_addr = c_q;
			wr_data = '0;
		end else if (wf_q) begin
			wr_addr = k0_q;
			wr_data = d0_q;
		end else begin
			wr_addr = k1_q;
			wr_data = d1_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= PASS_CLEAR;
			run_q  <= 1'b0;
			c_q    <= '0;
			v_s1   <= 1'b0;
			wf_q   <= 1'b0;
			ws_q   <= 1'b0;
		end else begin
			if (start) begin
				mode_q <= mode;
				run_q  <= 1'b1;
				c_q    <= '0;
			end else if (run_q) begin
				if (is_last) begin
					run_q <= 1'b0;
				end else begin
					c_q <= c_q + AW'(1);
				end
			end
			v_s1 <= issue;
			wf_q <= comp;
			ws_q <= wf_q;
		end
	end

	always_ff @(posedge clk) begin
		h_s1    <= c_q[0];
		last_s1 <= is_last;
		k0_s1   <= k0;
		k1_s1   <= k1;
		if (v_s1 && !h_s1) begin
			a_q <= rd_data;
		end
		if (comp) begin
			k0_q    <= k0_s1;
			k1_q    <= k1_s1;
			d0_q    <= d0;
			d1_q    <= d1;
			wlast_q <= last_s1;
		end
	end

endmodule

`default_nettype wire

// ===== src/grid_cycle_cover_counter.sv =====
// Top level: plug DP cycle cover counter with sequencer, banks and result register.
//
// Cells enter on cell_valid/cell_stall, one beat per cell in row-major order,
// with cell_open, new_grid and last_cell. A beat with last_cell set yields one
// beat on ways_valid/ways_stall carrying the cover count modulo 2^64.
// grid_width is written through cfg_wr_en/cfg_wr_data; the user must write it
// only while the block is idle, which the block itself does not enforce. The
// first cell of a row runs the row shift pass before its cell pass; a new_grid
// cell adds a clearing pass over all 2^(MAX_WIDTH+1) entries first. The rate is
// set by the single read port of the source bank: two reads per pair of profiles.
// cell_stall stays high until the cell is finished; one cell is worked at a time.
// Reset clears both banks in a clearing pass over all 2^(MAX_WIDTH+1) entries,
// with cell_stall high meanwhile; grid_width returns to 1.
// A waiting result sits in the output register; new cells are taken while it
// waits, and a further result holds in the sequencer until ways_stall drops.
`default_nettype none

module grid_cycle_cover_counter #(
	parameter int MAX_WIDTH = 12
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [gccc_pkg::GRID_WIDTH_W-1:0] cfg_wr_data,
	input  wire logic                              cell_valid,
	output      logic                              cell_stall,
	input  wire logic                              cell_open,
	input  wire logic                              new_grid,
	input  wire logic                              last_cell,
	output      logic                              ways_valid,
	input  wire logic                              ways_stall,
	output      logic [gccc_pkg::WAYS_W-1:0]       ways
);

	import gccc_pkg::*;

	localparam int AW    = MAX_WIDTH + 1;
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int DEPTH = 2 ** AW;

	gccc_state_t                state_q;
	gccc_state_t                state_d;
	logic [GRID_WIDTH_W-1:0]    gw_q;
	logic                       bank_q;
	logic [CW-1:0]              col_q;
	logic [WW-1:0]              w_q;
	logic                       open_q;
	logic                       last_q;
	logic [WAYS_W-1:0]          cnt0_q;
	logic [WAYS_W-1:0]          ways_q;
	logic                       ways_valid_q;

	logic                       accept;
	logic [WW-1:0]              w_eff;
	logic [CW-1:0]              colx;
	logic                       start;
	pass_mode_t                 mode;
	logic                       emit_fire;

	eng_ctl_t                   ctl;
	logic [AW-1:0]              rd_addr;
	logic [AW-1:0]              wr_addr;
	logic [WAYS_W-1:0]          wr_data;
	logic [WAYS_W-1:0]          rd_data;
	logic [WAYS_W-1:0]          rd0;
	logic [WAYS_W-1:0]          rd1;
	logic                       w0_en;
	logic                       w1_en;
	logic [WAYS_W-1:0]          w0_data;

	assign cell_stall = (state_q != ST_IDLE);
	assign accept     = cell_valid && !cell_stall;
	assign ways_valid = ways_valid_q;
	assign ways       = ways_q;
	assign emit_fire  = (state_q == ST_EMIT) && (!ways_valid_q || !ways_stall);

	always_comb begin
		if (gw_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(gw_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(gw_q);
		end
		if (new_grid || (32'(col_q) >= 32'(w_eff))) begin
			colx = '0;
		end else begin
			colx = col_q;
		end
	end

	always_comb begin
		state_d = state_q;
		start   = 1'b0;
		mode    = PASS_CLEAR;
		case (state_q)
			ST_BOOT: begin
				start   = 1'b1;
				mode    = PASS_CLEAR;
				state_d = ST_BOOT_CLR;
			end
			ST_BOOT_CLR: begin
				if (ctl.done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					start = 1'b1;
					if (new_grid) begin
						mode    = PASS_CLEAR;
						state_d = ST_CLEAR;
					end else if (colx == '0) begin
						mode    = PASS_SHIFT;
						state_d = ST_SHIFT;
					end else begin
						mode    = PASS_CELL;
						state_d = ST_CELL;
					end
				end
			end
			ST_CLEAR: begin
				if (ctl.done) begin
					start   = 1'b1;
					mode    = PASS_SHIFT;
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				if (ctl.done) begin
					start   = 1'b1;
					mode    = PASS_CELL;
					state_d = ST_CELL;
				end
			end
			ST_CELL: begin
				if (ctl.done) begin
					state_d = last_q ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (emit_fire) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_BOOT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_BOOT;
			gw_q         <= GRID_WIDTH_W'(1);
			bank_q       <= 1'b0;
			col_q        <= '0;
			w_q          <= WW'(1);
			ways_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				gw_q <= cfg_wr_data;
			end
			if (accept) begin
				col_q <= colx;
				w_q   <= w_eff;
			end
			if (ctl.done) begin
				case (state_q)
					ST_BOOT_CLR, ST_CLEAR: begin
						bank_q <= 1'b0;
					end
					ST_SHIFT: begin
						bank_q <= ~bank_q;
					end
					ST_CELL: begin
						bank_q <= ~bank_q;
						if (32'(col_q) + 32'd1 >= 32'(w_q)) begin
							col_q <= '0;
						end else begin
							col_q <= col_q + CW'(1);
						end
					end
					default: begin
						bank_q <= bank_q;
					end
				endcase
			end
			if (emit_fire) begin
				ways_valid_q <= 1'b1;
			end else if (!ways_stall) begin
				ways_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			open_q <= cell_open;
			last_q <= last_cell;
		end
		if ((state_q == ST_CELL) && ctl.wr_en && (wr_addr == '0)) begin
			cnt0_q <= wr_data;
		end
		if (emit_fire) begin
			ways_q <= cnt0_q;
		end
	end

	gccc_engine #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.mode      (mode),
		.cell_open (open_q),
		.col       (col_q),
		.width     (w_q),
		.ctl       (ctl),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	// Write the destination bank; a clearing pass writes both.
	assign w0_en   = ctl.wr_en && (ctl.wr_all || bank_q);
	assign w1_en   = ctl.wr_en && (ctl.wr_all || !bank_q);
	assign w0_data = (ctl.wr_all && (wr_addr == '0)) ? WAYS_W'(1) : wr_data;
	assign rd_data = bank_q ? rd1 : rd0;

	gccc_ram #(
		.WIDTH (WAYS_W),
		.DEPTH (DEPTH)
	) u_bank0 (
		.clk     (clk),
		.wr_en   (w0_en),
		.wr_addr (wr_addr),
		.wr_data (w0_data),
		.rd_en   (ctl.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd0)
	);

	gccc_ram #(
		.WIDTH (WAYS_W),
		.DEPTH (DEPTH)
	) u_bank1 (
		.clk     (clk),
		.wr_en   (w1_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (ctl.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd1)
	);

`include "grid_cycle_cover_counter_assert.svh"

	`GCCC_ASSERT_NOW(a_no_write_idle, clk, arst_n, (state_q == ST_IDLE) || (state_q == ST_EMIT), !ctl.wr_en, "bank written outside a pass")
	`GCCC_ASSERT_NOW(a_done_in_pass, clk, arst_n, ctl.done, (state_q == ST_BOOT_CLR) || (state_q == ST_CLEAR) || (state_q == ST_SHIFT) || (state_q == ST_CELL), "pass done outside a pass state")
	`GCCC_ASSERT_NOW(a_col_in_row, clk, arst_n, (state_q == ST_CELL), 32'(col_q) < 32'(w_q), "column beyond row width")
	`GCCC_ASSERT_NEXT(a_result_from_emit, clk, arst_n, (state_q != ST_EMIT) && !(ways_valid_q && ways_stall), !ways_valid_q, "result beat without an emit")

endmodule

`default_nettype wire
